### rtl/fjs_pkg.sv
package fjs_pkg;

  localparam int unsigned ARR_W           = 32;
  localparam int unsigned SVC_W           = 32;
  localparam int unsigned ID_W            = 32;
  localparam int unsigned TIME_W          = 48;
  localparam int unsigned LIMIT_W         = 5;
  localparam int unsigned QUEUE_DEPTH_DEF = 16;

  localparam logic [LIMIT_W-1:0] QUEUE_LIMIT_RST = LIMIT_W'(16);
  localparam logic [ID_W-1:0]    FIRST_JOB_ID    = ID_W'(1);

  // Input opcodes.
  localparam logic OP_ARRIVE = 1'b0;
  localparam logic OP_FLUSH  = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_POP  = 3'b010,
    S_LAST = 3'b100
  } state_e;

  // One waiting job as it sits in the queue memory.
  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [SVC_W-1:0] svc;
  } entry_t;

  function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
                                                 input logic [TIME_W-1:0] b);
    logic [TIME_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TIME_W] ? {TIME_W{1'b1}} : s[TIME_W-1:0];
  endfunction

endpackage

### rtl/bounded_fifo_job_server.sv
// Channel  | valid       | stall       | payload
// ---------+-------------+-------------+----------------------------------------------
// in       | in_valid_i  | in_stall_o  | op_i, arrival_time_i, service_time_i
// out      | out_valid_o | out_stall_i | job_id_o, finish_time_o, rejected_o,
//          |             |             | last_of_run_o, no_result_o
// cfg      | cfg_we_i    | -           | cfg_wdata_i (queue_limit)
//
// An arrival takes a pop step per waiting job it drains, then the final step;
// a flush takes a pop step per drained job, or just the final step when none
// waits. Entries are read ahead, so pops go out one per cycle but for stalls.
// Reset clears the pointers, count, busy time and job counter; the queue
// memory is not cleared, and no entry is read before it is written.
// A stall on the output freezes the pop and final steps; input is taken only when idle.
module bounded_fifo_job_server #(
  parameter int unsigned QUEUE_DEPTH = fjs_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [fjs_pkg::LIMIT_W-1:0]   cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          op_i,
  input  logic [fjs_pkg::ARR_W-1:0]     arrival_time_i,
  input  logic [fjs_pkg::SVC_W-1:0]     service_time_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [fjs_pkg::ID_W-1:0]      job_id_o,
  output logic [fjs_pkg::TIME_W-1:0]    finish_time_o,
  output logic                          rejected_o,
  output logic                          last_of_run_o,
  output logic                          no_result_o
);
  import fjs_pkg::*;

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned LIM_W = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  state_e             state_q, state_d;
  logic               op_q;
  logic [ARR_W-1:0]   arr_q;
  logic [SVC_W-1:0]   svc_q;
  logic [ID_W-1:0]    id_q;
  logic               popped_q;
  logic [PTR_W-1:0]   head_q, head_d, tail_q, tail_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic [TIME_W-1:0]  busy_q, busy_d;
  logic [ID_W-1:0]    next_id_q;
  logic [LIMIT_W-1:0] limit_q;

  logic               out_valid_q;
  logic [ID_W-1:0]    out_id_q;
  logic [TIME_W-1:0]  out_fin_q;
  logic               out_rej_q, out_last_q, out_none_q;

  logic               accept, out_free;
  logic               in_cont, pop_more, pop_last, start_now, full;
  logic [LIM_W-1:0]   lim;
  logic [TIME_W-1:0]  arr_w, pop_busy;
  logic [CNT_W-1:0]   rem;
  logic [PTR_W-1:0]   head_nx;
  entry_t             rd_ent, wr_ent;
  logic               rd_en, wr_en;
  logic [PTR_W-1:0]   rd_addr;

  logic               emit, e_rej, e_last, e_none;
  logic [ID_W-1:0]    e_id;
  logic [TIME_W-1:0]  e_fin;

  fjs_mem #(
    .DEPTH(QUEUE_DEPTH)
  ) u_mem (
    .clk_i    (clk_i),
    .wr_en_i  (wr_en),
    .wr_addr_i(tail_q),
    .wr_data_i(wr_ent),
    .rd_en_i  (rd_en),
    .rd_addr_i(rd_addr),
    .rd_data_o(rd_ent)
  );

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && (state_q == S_IDLE);
  assign out_free   = !out_valid_q || !out_stall_i;

  assign lim = (LIM_W'(limit_q) > LIM_W'(QUEUE_DEPTH)) ? LIM_W'(QUEUE_DEPTH)
                                                        : LIM_W'(limit_q);

  assign in_cont = (count_q != '0) &&
                   ((op_i == OP_FLUSH) || (TIME_W'(arrival_time_i) >= busy_q));

  assign arr_w    = TIME_W'(arr_q);
  assign pop_busy = sat_add(busy_q, TIME_W'(rd_ent.svc));
  assign rem      = count_q - 1'b1;
  assign head_nx  = ptr_inc(head_q);
  assign pop_more = (rem != '0) && ((op_q == OP_FLUSH) || (arr_w >= pop_busy));
  // For an arrival, the last pop closes the run only if the new job then waits.
  assign pop_last = (op_q == OP_FLUSH) ? (rem == '0)
                                       : ((arr_w < pop_busy) && (LIM_W'(rem) < lim));
  assign start_now = (arr_w >= busy_q);
  assign full      = (LIM_W'(count_q) >= lim);
  assign wr_ent    = '{id: id_q, svc: svc_q};

  // Writes happen only in the final step, and the next read comes in the step
  // after it at the earliest, so a read always sees the entry already written.
  always_comb begin
    state_d = state_q;
    head_d  = head_q;
    tail_d  = tail_q;
    count_d = count_q;
    busy_d  = busy_q;
    rd_en   = 1'b0;
    rd_addr = head_q;
    wr_en   = 1'b0;
    emit    = 1'b0;
    e_id    = '0;
    e_fin   = '0;
    e_rej   = 1'b0;
    e_last  = 1'b0;
    e_none  = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (in_cont) begin
            rd_en   = 1'b1;
            state_d = S_POP;
          end else begin
            state_d = S_LAST;
          end
        end
      end
      S_POP: begin
        if (out_free) begin
          emit    = 1'b1;
          e_id    = rd_ent.id;
          e_fin   = pop_busy;
          e_last  = pop_last;
          busy_d  = pop_busy;
          head_d  = head_nx;
          count_d = rem;
          if (pop_more) begin
            rd_en   = 1'b1;
            rd_addr = head_nx;
          end else if (op_q == OP_FLUSH) begin
            state_d = S_IDLE;
          end else begin
            state_d = S_LAST;
          end
        end
      end
      S_LAST: begin
        if (out_free) begin
          state_d = S_IDLE;
          e_last  = 1'b1;
          if (op_q == OP_FLUSH) begin
            emit   = 1'b1;
            e_none = 1'b1;
          end else if (start_now) begin
            busy_d = sat_add(arr_w, TIME_W'(svc_q));
            emit   = 1'b1;
            e_id   = id_q;
            e_fin  = busy_d;
          end else if (full) begin
            emit  = 1'b1;
            e_id  = id_q;
            e_rej = 1'b1;
          end else begin
            wr_en   = 1'b1;
            tail_d  = ptr_inc(tail_q);
            count_d = count_q + 1'b1;
            if (!popped_q) begin
              emit   = 1'b1;
              e_id   = id_q;
              e_none = 1'b1;
            end
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '0;
      tail_q      <= '0;
      count_q     <= '0;
      busy_q      <= '0;
      next_id_q   <= FIRST_JOB_ID;
      limit_q     <= QUEUE_LIMIT_RST;
      popped_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
      busy_q  <= busy_d;
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
      if (accept) begin
        popped_q <= 1'b0;
        if (op_i == OP_ARRIVE) begin
          next_id_q <= next_id_q + 1'b1;
        end
      end else if ((state_q == S_POP) && out_free) begin
        popped_q <= 1'b1;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q  <= op_i;
      arr_q <= arrival_time_i;
      svc_q <= service_time_i;
      id_q  <= next_id_q;
    end
    if (emit) begin
      out_id_q   <= e_id;
      out_fin_q  <= e_fin;
      out_rej_q  <= e_rej;
      out_last_q <= e_last;
      out_none_q <= e_none;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign job_id_o      = out_id_q;
  assign finish_time_o = out_fin_q;
  assign rejected_o    = out_rej_q;
  assign last_of_run_o = out_last_q;
  assign no_result_o   = out_none_q;

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(QUEUE_DEPTH))
    else $error("wait count exceeds queue depth");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_POP) |-> (count_q != '0))
    else $error("pop with an empty queue");

  a_accept_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> ((state_q == S_POP) || (state_q == S_LAST)))
    else $error("accepted item not processed");

  a_none_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && no_result_o) |-> ((finish_time_o == '0) && !rejected_o))
    else $error("empty result carries a finish time or reject");
`endif

endmodule

### rtl/fjs_mem.sv
module fjs_mem #(
  parameter int unsigned DEPTH = fjs_pkg::QUEUE_DEPTH_DEF,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                 clk_i,
  input  logic                 wr_en_i,
  input  logic [AW-1:0]        wr_addr_i,
  input  fjs_pkg::entry_t      wr_data_i,
  input  logic                 rd_en_i,
  input  logic [AW-1:0]        rd_addr_i,
  output fjs_pkg::entry_t      rd_data_o
);
  import fjs_pkg::*;

  entry_t mem_q [DEPTH];
  entry_t rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Read data holds until the next read, so a stalled pop keeps its entry.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_q;

endmodule

### bench/bounded_fifo_job_server_tb.sv
module bounded_fifo_job_server_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import fjs_pkg::*;

  localparam int unsigned QUIET_LIMIT   = 2000;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned END_CYCLES    = 20;
  localparam int unsigned PHASE_ITEMS   = 56;
  localparam longint unsigned TIME_CEILING = 64'hFFFF_FFFF_FFFF;

  typedef struct packed {
    logic [ID_W-1:0]   job_id;
    logic [TIME_W-1:0] finish_time;
    logic              rejected;
    logic              last_of_run;
    logic              no_result;
  } job_outcome_t;

  typedef enum logic [1:0] {
    RX_FREE,
    RX_SPARSE,
    RX_TOGGLE,
    RX_HEAVY
  } rx_mode_e;

  logic                clk_i          = 1'b0;
  logic                rst_ni         = 1'b0;
  logic                cfg_we_i       = 1'b0;
  logic [LIMIT_W-1:0]  cfg_wdata_i    = '0;
  logic                in_valid_i     = 1'b0;
  logic                in_stall_o;
  logic                op_i           = OP_ARRIVE;
  logic [ARR_W-1:0]    arrival_time_i = '0;
  logic [SVC_W-1:0]    service_time_i = '0;
  logic                out_valid_o;
  logic                out_stall_i    = 1'b0;
  logic [ID_W-1:0]     job_id_o;
  logic [TIME_W-1:0]   finish_time_o;
  logic                rejected_o;
  logic                last_of_run_o;
  logic                no_result_o;

  bounded_fifo_job_server dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .op_i           (op_i),
    .arrival_time_i (arrival_time_i),
    .service_time_i (service_time_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .job_id_o       (job_id_o),
    .finish_time_o  (finish_time_o),
    .rejected_o     (rejected_o),
    .last_of_run_o  (last_of_run_o),
    .no_result_o    (no_result_o)
  );

  // Server state as the testbench sees it.
  entry_t              model_waiting[$];
  logic [TIME_W-1:0]   model_busy_until = '0;
  logic [ID_W-1:0]     model_next_id    = FIRST_JOB_ID;
  logic [LIMIT_W-1:0]  model_limit      = QUEUE_LIMIT_RST;

  job_outcome_t        job_outcomes[$];
  int unsigned         mismatch_count = 0;
  int unsigned         burst_left     = 0;
  int unsigned         stall_left     = 0;
  rx_mode_e            rx_mode        = RX_FREE;

  initial begin : clock_gen
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [TIME_W-1:0] add_saturating(input logic [TIME_W-1:0] a,
                                                       input logic [SVC_W-1:0] b);
    logic [TIME_W:0] total;
    total = {1'b0, a} + (TIME_W+1)'(b);
    return total[TIME_W] ? TIME_CEILING[TIME_W-1:0] : total[TIME_W-1:0];
  endfunction

  function automatic void record_outcome(input logic [ID_W-1:0] id,
                                         input logic [TIME_W-1:0] fin,
                                         input logic rej, input logic none);
    job_outcome_t res;
    res.job_id      = id;
    res.finish_time = fin;
    res.rejected    = rej;
    res.last_of_run = 1'b0;
    res.no_result   = none;
    job_outcomes.push_back(res);
  endfunction

  // The head job starts the moment the server frees up.
  function automatic void start_waiting_job();
    entry_t job;
    job = model_waiting.pop_front();
    model_busy_until = add_saturating(model_busy_until, job.svc);
    record_outcome(job.id, model_busy_until, 1'b0, 1'b0);
  endfunction

  function automatic void serve_item(input logic op, input logic [ARR_W-1:0] arr,
                                     input logic [SVC_W-1:0] svc);
    int unsigned      eff_limit;
    int unsigned      prior_count;
    logic [ID_W-1:0]  id;
    entry_t           job;
    job_outcome_t     final_outcome;
    eff_limit   = (model_limit > QUEUE_DEPTH_DEF) ? QUEUE_DEPTH_DEF : model_limit;
    prior_count = job_outcomes.size();
    if (op == OP_FLUSH) begin
      while (model_waiting.size() != 0) start_waiting_job();
      if (job_outcomes.size() == prior_count) record_outcome('0, '0, 1'b0, 1'b1);
    end else begin
      id = model_next_id;
      model_next_id = model_next_id + 1'b1;
      while (model_waiting.size() != 0 && arr >= model_busy_until) start_waiting_job();
      if (arr >= model_busy_until) begin
        model_busy_until = add_saturating(TIME_W'(arr), svc);
        record_outcome(id, model_busy_until, 1'b0, 1'b0);
      end else if (model_waiting.size() >= eff_limit) begin
        record_outcome(id, '0, 1'b1, 1'b0);
      end else begin
        job.id  = id;
        job.svc = svc;
        model_waiting.push_back(job);
        if (job_outcomes.size() == prior_count) record_outcome(id, '0, 1'b0, 1'b1);
      end
    end
    final_outcome = job_outcomes.pop_back();
    final_outcome.last_of_run = 1'b1;
    job_outcomes.push_back(final_outcome);
  endfunction

  task automatic send_item(input logic op, input logic [ARR_W-1:0] arr,
                           input logic [SVC_W-1:0] svc);
    int unsigned gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 3) != 0) gap = $urandom_range(1, 8);
    end
    burst_left--;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    op_i           <= op;
    arrival_time_i <= arr;
    service_time_i <= svc;
    do @(posedge clk_i); while (in_stall_o);
    serve_item(op, arr, svc);
  endtask

  task automatic await_all_results();
    in_valid_i <= 1'b0;
    while (job_outcomes.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_limit(input logic [LIMIT_W-1:0] value);
    cfg_wdata_i <= value;
    cfg_we_i    <= 1'b1;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    model_limit = value;
  endtask

  task automatic test_empty_flush();
    // Flush fields carry no meaning, so they are driven to all ones here.
    send_item(OP_FLUSH, '1, '1);
  endtask

  task automatic test_start_and_queue();
    logic [ARR_W-1:0] t;
    t = model_busy_until[ARR_W-1:0];
    send_item(OP_ARRIVE, t, 1);
    send_item(OP_ARRIVE, t, 100);
    send_item(OP_ARRIVE, t, 5);
    // Both waiting jobs are done by this arrival, so it drains them and starts.
    send_item(OP_ARRIVE, t + 300, 7);
    // An arrival earlier than the previous one finds the server busy and waits.
    send_item(OP_ARRIVE, t + 250, 9);
    send_item(OP_FLUSH, '0, '0);
  endtask

  task automatic test_limit_zero();
    logic [ARR_W-1:0] t;
    await_all_results();
    write_limit('0);
    t = model_busy_until[ARR_W-1:0];
    send_item(OP_ARRIVE, t, 50);
    send_item(OP_ARRIVE, t, 3);
  endtask

  task automatic test_full_queue();
    logic [ARR_W-1:0] t;
    await_all_results();
    // The top register value behaves as the queue depth.
    write_limit('1);
    t = model_busy_until[ARR_W-1:0];
    send_item(OP_ARRIVE, t, 10);
    for (int i = 0; i < QUEUE_DEPTH_DEF; i++) send_item(OP_ARRIVE, t, i + 1);
    send_item(OP_ARRIVE, t, 7);
    // A late arrival drains the whole queue and then starts itself.
    send_item(OP_ARRIVE, t + 100000, 3);
  endtask

  task automatic run_random_phase(input logic [LIMIT_W-1:0] limit_value,
                                  input int unsigned count);
    longint unsigned   clock_now;
    int unsigned       pick;
    logic [SVC_W-1:0]  svc;
    logic [ARR_W-1:0]  arr;
    await_all_results();
    write_limit(limit_value);
    clock_now = 64'(model_busy_until);
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 94) svc = $urandom_range(1, 48);
      else if (pick < 99) svc = $urandom_range(1, 2000);
      else svc = $urandom_range(1 << 12, 1 << 20);
      pick = $urandom_range(0, 99);
      if (pick < 5) begin
        send_item(OP_FLUSH, $urandom, $urandom);
      end else if (pick < 8) begin
        arr = (clock_now > 40) ? ARR_W'(clock_now - 64'($urandom_range(1, 40))) : '0;
        send_item(OP_ARRIVE, arr, svc);
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 25) clock_now += 0;
        else if (pick < 95) clock_now += 64'($urandom_range(1, 30));
        else if (pick < 99) clock_now += 64'($urandom_range(100, 4000));
        else clock_now += 64'($urandom_range(1 << 16, 1 << 20));
        send_item(OP_ARRIVE, clock_now[ARR_W-1:0], svc);
      end
      if ($urandom_range(0, 99) == 0) await_all_results();
    end
  endtask

  task automatic test_time_ceiling();
    await_all_results();
    write_limit(QUEUE_LIMIT_RST);
    send_item(OP_ARRIVE, '1, '1);
    send_item(OP_ARRIVE, '1, 32'hAAAA_AAAA);
    send_item(OP_ARRIVE, '1, 32'h5555_5555);
    send_item(OP_FLUSH, '0, '0);
  endtask

  // The receiver switches between a few stall habits for random stretches.
  always @(posedge clk_i) begin : receiver_pattern
    if (stall_left != 0) begin
      stall_left--;
    end else begin
      rx_mode    = rx_mode_e'($urandom_range(0, 3));
      stall_left = $urandom_range(4, 40);
    end
    case (rx_mode)
      RX_FREE:   out_stall_i <= 1'b0;
      RX_SPARSE: out_stall_i <= ($urandom_range(0, 3) == 0);
      RX_TOGGLE: out_stall_i <= ~out_stall_i;
      default:   out_stall_i <= ($urandom_range(0, 9) < 7);
    endcase
  end

  always @(posedge clk_i) begin : check_outcomes
    job_outcome_t seen;
    job_outcome_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      seen = {job_id_o, finish_time_o, rejected_o, last_of_run_o, no_result_o};
      if (job_outcomes.size() == 0) begin
        if (mismatch_count < 10)
          $display("unexpected result: id %0d finish %0d rej %0b last %0b none %0b",
                   seen.job_id, seen.finish_time, seen.rejected, seen.last_of_run,
                   seen.no_result);
        mismatch_count++;
      end else begin
        want = job_outcomes.pop_front();
        if (seen !== want) begin
          if (mismatch_count < 10)
            $display({"result mismatch: want id %0d finish %0d rej %0b last %0b none %0b,",
                      " got id %0d finish %0d rej %0b last %0b none %0b"},
                     want.job_id, want.finish_time, want.rejected, want.last_of_run,
                     want.no_result, seen.job_id, seen.finish_time, seen.rejected,
                     seen.last_of_run, seen.no_result);
          mismatch_count++;
        end
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    forever begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet = 0;
      else quiet++;
      if (quiet == QUIET_LIMIT) begin
        $display("bounded_fifo_job_server test failed");
        $finish;
      end
    end
  end

  initial begin : stimulus
    logic [LIMIT_W-1:0] phase_limits [7];
    phase_limits = '{5'd16, 5'd3, 5'd0, 5'd31, 5'd1, 5'd17, 5'd5};
    phase_limits[6] = LIMIT_W'($urandom_range(2, 15));
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_flush();
    test_start_and_queue();
    test_limit_zero();
    test_full_queue();
    foreach (phase_limits[p]) run_random_phase(phase_limits[p], PHASE_ITEMS);
    test_time_ceiling();
    await_all_results();
    repeat (END_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("bounded_fifo_job_server test passed");
    end else begin
      $display("bounded_fifo_job_server test failed");
    end
    $finish;
  end

endmodule
